// File: design/nlc_pkg.sv
// Shared types and constants for the numeric literal checker.
// Holds the byte class and parse phase codes and the byte classifier.
// Depends on nothing.
`default_nettype none

package nlc_pkg;

  // Class of one string byte as seen by the parser.
  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_DIGIT = 3'd1,
    CLS_SPACE = 3'd2,
    CLS_SIGN  = 3'd3,
    CLS_DOT   = 3'd4,
    CLS_EXP   = 3'd5,
    CLS_END   = 3'd6
  } nlc_class_e;

  // Parse phase of the string being checked.
  typedef enum logic [3:0] {
    PH_LEAD    = 4'd0,
    PH_SIGN    = 4'd1,
    PH_INT     = 4'd2,
    PH_DOTONLY = 4'd3,
    PH_FRAC    = 4'd4,
    PH_EXPMARK = 4'd5,
    PH_EXPSIGN = 4'd6,
    PH_EXPDIG  = 4'd7,
    PH_TRAIL   = 4'd8,
    PH_REJECT  = 4'd9
  } nlc_phase_e;

  // A classified byte moving between the parts of the block.
  typedef struct packed {
    logic       valid;
    nlc_class_e cls;
  } nlc_flow_t;

  localparam logic [7:0] ChrNul   = 8'h00;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;
  localparam logic [7:0] ChrPlus  = 8'h2B;
  localparam logic [7:0] ChrMinus = 8'h2D;
  localparam logic [7:0] ChrDot   = 8'h2E;
  localparam logic [7:0] ChrExp   = 8'h65;

  function automatic nlc_class_e nlc_classify(input logic [7:0] c);
    nlc_class_e cls;
    if (c == ChrNul) begin
      cls = CLS_END;
    end else if (c >= ChrZero && c <= ChrNine) begin
      cls = CLS_DIGIT;
    end else if (c == ChrSpace || (c >= ChrTab && c <= ChrCr)) begin
      cls = CLS_SPACE;
    end else if (c == ChrPlus || c == ChrMinus) begin
      cls = CLS_SIGN;
    end else if (c == ChrDot) begin
      cls = CLS_DOT;
    end else if (c == ChrExp) begin
      cls = CLS_EXP;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// File: design/nlc_front.sv
// Front part of the numeric literal checker: takes string bytes and
// registers their class. Depends on nlc_pkg.
`default_nettype none

module nlc_front
  import nlc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       char_valid_i,
  output logic            char_stall_o,
  input  wire logic [7:0] char_byte_i,
  output nlc_flow_t       push_o,
  input  wire logic       push_full_i
);

  logic       valid_q, valid_d;
  nlc_class_e cls_q, cls_d;
  logic       take, hand_on;

  // The stage frees itself whenever the queue takes its entry.
  assign hand_on      = valid_q && !push_full_i;
  assign char_stall_o = valid_q && push_full_i;
  assign take         = char_valid_i && !char_stall_o;

  always_comb begin
    valid_d = valid_q;
    cls_d   = cls_q;
    if (take) begin
      valid_d = 1'b1;
      cls_d   = nlc_classify(char_byte_i);
    end else if (hand_on) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
  end

  assign push_o.valid = valid_q;
  assign push_o.cls   = cls_q;

endmodule

`default_nettype wire

// File: design/nlc_queue.sv
// Short queue of classified bytes between front and back.
// Depends on nlc_pkg.
`default_nettype none

module nlc_queue
  import nlc_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire nlc_flow_t push_i,
  output logic           full_o,
  output nlc_flow_t      head_o,
  input  wire logic      pop_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  nlc_class_e       mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cls;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.cls   = mem_q[rd_ptr_q];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue holds more entries than it has room for");

endmodule

`default_nettype wire

// File: design/nlc_back.sv
// Back part of the numeric literal checker: the parse phase machine and
// the verdict output register. Depends on nlc_pkg.
`default_nettype none

module nlc_back
  import nlc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire nlc_flow_t head_i,
  output logic           pop_o,
  output logic           number_valid_o,
  input  wire logic      number_stall_i,
  output logic           is_number_o
);

  nlc_phase_e phase_q, phase_d;
  logic       out_valid_q, out_valid_d;
  logic       verdict_q, verdict_d;
  logic       accepting, is_end, out_free;

  assign is_end   = (head_i.cls == CLS_END);
  assign out_free = !out_valid_q || !number_stall_i;
  // Ordinary bytes never wait; the terminator waits for a free verdict slot.
  assign pop_o    = head_i.valid && (!is_end || out_free);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (pop_o) begin
      case (phase_q)
        PH_LEAD: begin
          case (head_i.cls)
            CLS_SPACE: phase_d = PH_LEAD;
            CLS_SIGN:  phase_d = PH_SIGN;
            CLS_DIGIT: phase_d = PH_INT;
            CLS_DOT:   phase_d = PH_DOTONLY;
            default:   phase_d = PH_REJECT;
          endcase
        end
        PH_SIGN: begin
          case (head_i.cls)
            CLS_DIGIT: phase_d = PH_INT;
            CLS_DOT:   phase_d = PH_DOTONLY;
            default:   phase_d = PH_REJECT;
          endcase
        end
        PH_INT: begin
          case (head_i.cls)
            CLS_DIGIT: phase_d = PH_INT;
            CLS_DOT:   phase_d = PH_FRAC;
            CLS_EXP:   phase_d = PH_EXPMARK;
            CLS_SPACE: phase_d = PH_TRAIL;
            default:   phase_d = PH_REJECT;
          endcase
        end
        PH_DOTONLY: begin
          case (head_i.cls)
            CLS_DIGIT: phase_d = PH_FRAC;
            default:   phase_d = PH_REJECT;
          endcase
        end
        PH_FRAC: begin
          case (head_i.cls)
            CLS_DIGIT: phase_d = PH_FRAC;
            CLS_EXP:   phase_d = PH_EXPMARK;
            CLS_SPACE: phase_d = PH_TRAIL;
            default:   phase_d = PH_REJECT;
          endcase
        end
        PH_EXPMARK: begin
          case (head_i.cls)
            CLS_SIGN:  phase_d = PH_EXPSIGN;
            CLS_DIGIT: phase_d = PH_EXPDIG;
            default:   phase_d = PH_REJECT;
          endcase
        end
        PH_EXPSIGN: begin
          case (head_i.cls)
            CLS_DIGIT: phase_d = PH_EXPDIG;
            default:   phase_d = PH_REJECT;
          endcase
        end
        PH_EXPDIG: begin
          case (head_i.cls)
            CLS_DIGIT: phase_d = PH_EXPDIG;
            CLS_SPACE: phase_d = PH_TRAIL;
            default:   phase_d = PH_REJECT;
          endcase
        end
        PH_TRAIL: begin
          case (head_i.cls)
            CLS_SPACE: phase_d = PH_TRAIL;
            default:   phase_d = PH_REJECT;
          endcase
        end
        default: phase_d = PH_REJECT;
      endcase
      // The terminator always returns the machine to its start.
      if (is_end) begin
        phase_d = PH_LEAD;
      end
    end
  end

  // Outputs: the verdict register.
  always_comb begin
    accepting   = (phase_q == PH_INT) || (phase_q == PH_FRAC) ||
                  (phase_q == PH_EXPDIG) || (phase_q == PH_TRAIL);
    out_valid_d = out_valid_q && number_stall_i;
    verdict_d   = verdict_q;
    if (pop_o && is_end) begin
      out_valid_d = 1'b1;
      verdict_d   = accepting;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  assign number_valid_o = out_valid_q;
  assign is_number_o    = verdict_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_end) |=> (out_valid_q && phase_q == PH_LEAD))
    else $error("terminator did not give a verdict and restart the parse");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_o && is_end && out_valid_q && number_stall_i))
    else $error("terminator taken while a verdict still waits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_i.valid && !is_end) |-> pop_o)
    else $error("ordinary byte held back by the output side");

endmodule

`default_nettype wire

// File: design/numeric_literal_checker.sv
// Top level of the numeric literal checker.
// Instantiates nlc_front, nlc_queue and nlc_back; depends on nlc_pkg.
//
// The checker takes a text string one byte per request on the char channel
// and, when the zero byte that ends the string arrives, gives one request on
// the number channel whose is_number bit says whether the string was a
// decimal number: optional leading white space, an optional sign, digits
// with an optional dot and fraction (at least one digit in all), an optional
// lower case 'e' with optional sign and at least one digit, and optional
// trailing white space. Only the zero byte causes a verdict; it also puts the
// parser back to its start, so strings may follow one another directly. The
// block takes one byte in every clock cycle as long as the verdict side keeps
// up; the phase machine in the back part updates once per byte, which sets
// that rate. A zero byte that is taken is loaded into the class register,
// then into the queue, and its verdict then into the verdict register.
// While a verdict is stalled, ordinary bytes still flow through, but a
// following zero byte waits at the head of the queue; it and the bytes
// behind it fill the QUEUE_DEPTH queue entries and the class register, and
// only then is the char channel stalled.
`default_nettype none

module numeric_literal_checker
  import nlc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       char_valid_i,
  output logic            char_stall_o,
  input  wire logic [7:0] char_byte_i,
  output logic            number_valid_o,
  input  wire logic       number_stall_i,
  output logic            is_number_o
);

  nlc_flow_t push;
  nlc_flow_t head;
  logic      queue_full;
  logic      pop;

  // Front: classifies each byte and registers the class.
  nlc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (char_valid_i),
    .char_stall_o (char_stall_o),
    .char_byte_i  (char_byte_i),
    .push_o       (push),
    .push_full_i  (queue_full)
  );

  // Queue: lets the front carry on while a verdict is held.
  nlc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (queue_full),
    .head_o (head),
    .pop_i  (pop)
  );

  // Back: runs the phase machine and holds the verdict.
  nlc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .number_valid_o (number_valid_o),
    .number_stall_i (number_stall_i),
    .is_number_o    (is_number_o)
  );

endmodule

`default_nettype wire
